// ===== src/colz_pkg.sv =====
// ----------------------------------------------------------------------------
// colz_pkg
// Shared constants and types for the Collatz stopping-time checker.
// ----------------------------------------------------------------------------
`default_nettype none

package colz_pkg;

    // value digit processed per cycle by the serial datapath
    localparam int DIGIT_W = 8;

    localparam int VALUE_WIDTH_DEF = 128;
    localparam int SEED_W          = 64;
    localparam int STEP_W          = 64;
    localparam int HALF_W          = 64;
    localparam int OUT_W           = 2 * HALF_W;

    // configuration port
    localparam int APB_DW = 64;
    localparam int APB_AW = 4;

    localparam logic              REG_STEP_LIMIT = 1'b0;
    localparam logic [STEP_W-1:0] STEP_LIMIT_RST = 64'd1000;

    // running state carried from one digit to the next
    typedef struct packed {
        logic [1:0] carry;  // 3n+1 carry, up to 2
        logic       prev;   // top bit of previous digit (feeds 2n)
        logic       lt;     // new value below seed so far
        logic       one;    // new value equals one so far
    } t_dstate;

endpackage

`default_nettype wire

// ===== src/colz_digit_unit.sv =====
// ----------------------------------------------------------------------------
// colz_digit_unit
// One digit of a Collatz step (halve or 3n+1), plus running compares
// of the new value against the seed and against one.
// ----------------------------------------------------------------------------
`default_nettype none

module colz_digit_unit (
    input  wire logic [colz_pkg::DIGIT_W-1:0] i_x,
    input  wire logic                         i_next_lsb,
    input  wire logic                         i_first,
    input  wire logic                         i_last,
    input  wire logic                         i_odd,
    input  wire logic [colz_pkg::DIGIT_W-1:0] i_sd,
    input  wire colz_pkg::t_dstate            i_ds,
    output logic      [colz_pkg::DIGIT_W-1:0] o_nd,
    output colz_pkg::t_dstate                 o_ds
);

    localparam int DW = colz_pkg::DIGIT_W;

    logic [DW+1:0] sum;
    logic [DW-1:0] nd;
    logic [DW-1:0] one_ref;

    always_comb begin
        // 2x + x + carry, with 2x taking the top bit of the previous digit
        sum = {2'b00, i_x[DW-2:0], i_ds.prev} + {2'b00, i_x} + {{DW{1'b0}}, i_ds.carry};

        if (i_odd) begin
            nd = sum[DW-1:0];
        end else begin
            nd = {(i_last ? 1'b0 : i_next_lsb), i_x[DW-1:1]};
        end

        one_ref = i_first ? DW'(1) : '0;

        o_nd       = nd;
        o_ds.carry = sum[DW+1:DW];
        o_ds.prev  = i_x[DW-1];
        // LSB first: a higher digit that differs overrides the lower verdict
        if (nd < i_sd) begin
            o_ds.lt = 1'b1;
        end else if (nd > i_sd) begin
            o_ds.lt = 1'b0;
        end else begin
            o_ds.lt = i_ds.lt;
        end
        o_ds.one = i_ds.one && (nd == one_ref);
    end

endmodule

`default_nettype wire

// ===== src/colz_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// colz_cfg_regs
// APB-style register file holding the iteration budget.
// ----------------------------------------------------------------------------
`default_nettype none

module colz_cfg_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [colz_pkg::APB_AW-1:0] paddr,
    input  wire logic [colz_pkg::APB_DW-1:0] pwdata,
    output logic      [colz_pkg::APB_DW-1:0] prdata,
    output logic                             pready,
    output logic      [colz_pkg::STEP_W-1:0] o_step_limit
);

    logic [colz_pkg::STEP_W-1:0] r_step_limit;
    logic                        wr_en;
    logic                        reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[colz_pkg::APB_AW-1];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_limit <= colz_pkg::STEP_LIMIT_RST;
        end else if (wr_en && (reg_idx == colz_pkg::REG_STEP_LIMIT)) begin
            r_step_limit <= pwdata[colz_pkg::STEP_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            colz_pkg::REG_STEP_LIMIT: prdata = r_step_limit;
            default:                  prdata = '0;
        endcase
    end

    assign o_step_limit = r_step_limit;

endmodule

`default_nettype wire

// ===== src/colz_serial_core.sv =====
// ----------------------------------------------------------------------------
// colz_serial_core
// Digit-serial Collatz iterator: the working value circulates through a
// shift register one digit per cycle; one full circulation is one step.
// ----------------------------------------------------------------------------
`default_nettype none

module colz_serial_core #(
    parameter int VALUE_WIDTH = colz_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [colz_pkg::SEED_W-1:0] i_seed,
    input  wire logic [colz_pkg::STEP_W-1:0] i_step_limit,
    input  wire logic                        i_take,
    output logic                             o_busy,
    output logic                             o_done,
    output logic                             o_ok,
    output logic [((VALUE_WIDTH + colz_pkg::DIGIT_W - 1) / colz_pkg::DIGIT_W)
                  * colz_pkg::DIGIT_W - 1:0] o_value
);

    localparam int DW   = colz_pkg::DIGIT_W;
    localparam int NDIG = (VALUE_WIDTH + DW - 1) / DW;
    localparam int W    = NDIG * DW;
    localparam int CW   = $clog2(NDIG);
    localparam int TOPV = VALUE_WIDTH - (NDIG - 1) * DW;
    // bits of the top digit that lie above the value width
    localparam logic [DW-1:0] HIGH_MASK = ~DW'((1 << TOPV) - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_PASS  = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    localparam colz_pkg::t_dstate DS_START = '{carry: 2'd1, prev: 1'b0, lt: 1'b0, one: 1'b1};

    logic [1:0]                  r_state, n_state;
    logic [W-1:0]                r_val,   n_val;
    logic [W-DW-1:0]             r_new,   n_new;
    logic [W-1:0]                r_seed,  n_seed;
    logic [CW-1:0]               r_cnt,   n_cnt;
    logic [colz_pkg::STEP_W-1:0] r_step,  n_step;
    colz_pkg::t_dstate           r_ds,    n_ds;
    logic                        r_odd,   n_odd;
    logic                        r_ok,    n_ok;

    logic [DW-1:0]     nd;
    colz_pkg::t_dstate du_ds;
    logic              last;
    logic              ovf;

    assign last = (r_cnt == CW'(NDIG - 1));

    colz_digit_unit u_digit (
        .i_x        (r_val[DW-1:0]),
        .i_next_lsb (r_val[DW]),
        .i_first    (r_cnt == '0),
        .i_last     (last),
        .i_odd      (r_odd),
        .i_sd       (r_seed[DW-1:0]),
        .i_ds       (r_ds),
        .o_nd       (nd),
        .o_ds       (du_ds)
    );

    // 3n+1 spills past the value width
    assign ovf = r_odd && ((du_ds.carry != 2'd0) || du_ds.prev || ((nd & HIGH_MASK) != '0));

    always_comb begin
        n_state = r_state;
        n_val   = r_val;
        n_new   = r_new;
        n_seed  = r_seed;
        n_cnt   = r_cnt;
        n_step  = r_step;
        n_ds    = r_ds;
        n_odd   = r_odd;
        n_ok    = r_ok;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_val    = W'(i_seed);
                    n_seed   = W'(i_seed);
                    n_step   = '0;
                    n_ds     = DS_START;
                    n_ds.lt  = 1'b0;
                    n_ds.one = (i_seed == colz_pkg::SEED_W'(1));
                    n_ok     = 1'b0;
                    n_state  = (i_seed == '0) ? S_FIN : S_CHECK;
                end
            end
            S_CHECK: begin
                n_cnt = '0;
                n_odd = r_val[0];
                if (r_step == i_step_limit) begin
                    n_ok    = 1'b0;
                    n_state = S_FIN;
                end else if (r_ds.lt || r_ds.one) begin
                    n_ok    = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_ds    = DS_START;
                    n_state = S_PASS;
                end
            end
            S_PASS: begin
                // rotate the old value so it is whole again after the pass
                n_val  = {r_val[DW-1:0], r_val[W-1:DW]};
                n_seed = {r_seed[DW-1:0], r_seed[W-1:DW]};
                n_new  = {nd, r_new[W-DW-1:DW]};
                n_ds   = du_ds;
                n_cnt  = r_cnt + CW'(1);
                if (last) begin
                    if (ovf) begin
                        n_ok    = 1'b0;
                        n_state = S_FIN;
                    end else begin
                        n_val   = {nd, r_new};
                        n_step  = r_step + colz_pkg::STEP_W'(1);
                        n_state = S_CHECK;
                    end
                end
            end
            S_FIN: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_new  <= n_new;
        r_seed <= n_seed;
        r_cnt  <= n_cnt;
        r_step <= n_step;
        r_ds   <= n_ds;
        r_odd  <= n_odd;
        r_ok   <= n_ok;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_done  = (r_state == S_FIN);
    assign o_ok    = r_ok;
    assign o_value = r_val;

endmodule

`default_nettype wire

// ===== src/collatz_seed_verifier.sv =====
// ----------------------------------------------------------------------------
// collatz_seed_verifier
// Collatz stopping-time check of one 64-bit seed per transfer.
//
// Input channel: i_in_valid / o_in_stall carry i_seed. Output channel:
// o_out_valid / i_out_stall carry o_verified, o_final_low, o_final_high.
// The step limit (reset 1000) is written over the APB port at address 0.
// The user must write it only while the block is idle; the block does not
// enforce this. The working value sits in a shift register handled one
// 8-bit digit per cycle; one Collatz step is a check state followed by a
// pass over all NDIG = ceil(VALUE_WIDTH / 8) digits.
// One seed is in work at a time; o_in_stall stays high until the result is
// moved into the output register, and the next seed is taken while that
// result still waits. A stalled result holds; the core then waits with
// its own result until the output register frees.
// Reset clears the control state and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module collatz_seed_verifier #(
    parameter int VALUE_WIDTH = colz_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [colz_pkg::SEED_W-1:0] i_seed,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_verified,
    output logic      [colz_pkg::HALF_W-1:0] o_final_low,
    output logic      [colz_pkg::HALF_W-1:0] o_final_high,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [colz_pkg::APB_AW-1:0] paddr,
    input  wire logic [colz_pkg::APB_DW-1:0] pwdata,
    output logic      [colz_pkg::APB_DW-1:0] prdata,
    output logic                             pready
);

    localparam int DW    = colz_pkg::DIGIT_W;
    localparam int NDIG  = (VALUE_WIDTH + DW - 1) / DW;
    localparam int W     = NDIG * DW;
    localparam int OUT_W = colz_pkg::OUT_W;
    localparam int HW    = colz_pkg::HALF_W;

    logic [colz_pkg::STEP_W-1:0] step_limit;
    logic                        busy;
    logic                        done;
    logic                        ok;
    logic                        take;
    logic [W-1:0]                value;
    logic [OUT_W-1:0]            value_ext;

    logic                        r_out_valid;
    logic                        r_verified;
    logic [HW-1:0]               r_final_low;
    logic [HW-1:0]               r_final_high;

    colz_cfg_regs u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_step_limit (step_limit)
    );

    colz_serial_core #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_in_valid && !busy),
        .i_seed       (i_seed),
        .i_step_limit (step_limit),
        .i_take       (take),
        .o_busy       (busy),
        .o_done       (done),
        .o_ok         (ok),
        .o_value      (value)
    );

    generate
        if (W >= OUT_W) begin : g_trunc
            assign value_ext = value[OUT_W-1:0];
        end else begin : g_ext
            assign value_ext = {{(OUT_W - W){1'b0}}, value};
        end
    endgenerate

    // move the finished result out when the output register is free
    assign take = done && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_verified   <= ok;
            r_final_low  <= value_ext[HW-1:0];
            r_final_high <= value_ext[OUT_W-1:HW];
        end
    end

    assign o_in_stall   = busy;
    assign o_out_valid  = r_out_valid;
    assign o_verified   = r_verified;
    assign o_final_low  = r_final_low;
    assign o_final_high = r_final_high;

endmodule

`default_nettype wire

// ===== src/colz_checker.sv =====
// ----------------------------------------------------------------------------
// colz_checker
// Port-level checks of the Collatz checker's handshakes over time.
// ----------------------------------------------------------------------------
`default_nettype none

module colz_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_stall,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic                        o_verified,
    input wire logic [colz_pkg::HALF_W-1:0] o_final_low,
    input wire logic [colz_pkg::HALF_W-1:0] o_final_high
);

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a held result does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_verified)
            && $stable(o_final_low) && $stable(o_final_high))
        else $error("stalled result changed");

    // one seed at a time: busy right after a transfer in
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after transfer");

    // a new result appears only out of a busy cycle
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without work");

endmodule

bind collatz_seed_verifier colz_checker u_colz_checker (.*);

`default_nettype wire
